// ===== design/frx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types and constants of the sum-checked frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PAYLOAD_BYTES = 6;   // bytes summed per frame, 1..7
  localparam int unsigned SHOWN_BYTES   = 6;   // payload fields on the result
  localparam int unsigned IDX_W         = 3;   // byte slot counter width
  localparam int unsigned MISS_W        = 4;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'h80;
  localparam logic [BYTE_W-1:0] CHECKSUM_MASK_RST = 8'h7f;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST    = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER  = 2'd0,
    CFG_CHECKSUM_MASK = 2'd1,
    CFG_MISS_LIMIT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRAME_OK = 2'd0,
    ST_NO_START = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] checksum_mask;
    logic [MISS_W-1:0] miss_limit;
  } cfg_t;

  typedef struct packed {
    status_e                             status;
    logic [SHOWN_BYTES-1:0][BYTE_W-1:0] payload;
  } result_t;

endpackage
`default_nettype wire

// ===== design/frx_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frx_byte_if / frx_result_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface frx_byte_if;
  logic                        valid;
  logic                        ready;
  logic [frx_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_result_if;
  logic                          valid;
  logic                          ready;
  logic [frx_pkg::STATUS_W-1:0] frame_status;
  logic [frx_pkg::BYTE_W-1:0]   payload_0;
  logic [frx_pkg::BYTE_W-1:0]   payload_1;
  logic [frx_pkg::BYTE_W-1:0]   payload_2;
  logic [frx_pkg::BYTE_W-1:0]   payload_3;
  logic [frx_pkg::BYTE_W-1:0]   payload_4;
  logic [frx_pkg::BYTE_W-1:0]   payload_5;

  modport source (output valid, output frame_status, output payload_0,
                  output payload_1, output payload_2, output payload_3,
                  output payload_4, output payload_5, input ready);
  modport sink   (input valid, input frame_status, input payload_0,
                  input payload_1, input payload_2, input payload_3,
                  input payload_4, input payload_5, output ready);
endinterface
`default_nettype wire

// ===== design/frx_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frx_cfg_regs
// Configuration registers written through a plain indexed write port.
// ----------------------------------------------------------------------------
module frx_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [frx_pkg::BYTE_W-1:0]    cfg_data_i,
  output frx_pkg::cfg_t                       cfg_o
);
  import frx_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MARKER:  cfg_d.start_marker  = cfg_data_i;
        CFG_CHECKSUM_MASK: cfg_d.checksum_mask = cfg_data_i;
        CFG_MISS_LIMIT:    cfg_d.miss_limit    = cfg_data_i[MISS_W-1:0];
        default:           cfg_d = cfg_q;  // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker  <= START_MARKER_RST;
      cfg_q.checksum_mask <= CHECKSUM_MASK_RST;
      cfg_q.miss_limit    <= MISS_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/frx_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frx_in_stage
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module frx_in_stage (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  frx_byte_if.sink    rx,
  frx_byte_if.source  core
);
  import frx_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              take_in;

  // Refill in the same cycle the core drains the register.
  assign rx.ready = !valid_q || core.ready;
  assign take_in  = rx.valid && rx.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take_in) begin
      valid_d = 1'b1;
      byte_d  = rx.rx_byte;
    end else if (core.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign core.valid   = valid_q;
  assign core.rx_byte = byte_q;

endmodule
`default_nettype wire

// ===== design/frx_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frx_core
// Frame state machine, payload store, running sum and result register.
// ----------------------------------------------------------------------------
module frx_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire frx_pkg::cfg_t cfg_i,
  frx_byte_if.sink        in,
  frx_result_if.source    res
);
  import frx_pkg::*;

  phase_e                              phase_q, phase_d;
  logic [IDX_W-1:0]                    idx_q, idx_d;
  logic [MISS_W-1:0]                   miss_q, miss_d;
  logic [BYTE_W-1:0]                   sum_q, sum_d;
  logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] store_q, store_d;
  logic                                out_valid_q, out_valid_d;
  result_t                             out_q, out_d;

  logic              advance;
  logic              emit;
  logic [IDX_W-1:0]  idx_inc;
  logic [MISS_W-1:0] miss_inc;
  logic              miss_hit;
  logic [BYTE_W-1:0] b;

  // Take a byte when the result register is free or drains this cycle.
  assign in.ready = !out_valid_q || res.ready;
  assign advance  = in.valid && in.ready;
  assign b        = in.rx_byte;

  assign idx_inc  = idx_q + IDX_W'(1);
  assign miss_inc = miss_q + MISS_W'(1);
  assign miss_hit = (miss_inc >= cfg_i.miss_limit) || (miss_inc == '0);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    miss_d  = miss_q;
    sum_d   = sum_q;
    store_d = store_q;
    emit    = 1'b0;
    out_d   = out_q;

    if (advance) begin
      out_d.payload = '0;
      unique case (phase_q)
        PH_DATA: begin
          for (int j = 0; j < PAYLOAD_BYTES; j++) begin
            if (idx_q == IDX_W'(j)) begin
              store_d[j] = b;
            end
          end
          sum_d = sum_q + b;
          idx_d = idx_inc;
          if ((idx_inc >= IDX_W'(PAYLOAD_BYTES)) || (idx_inc == '0)) begin
            phase_d = PH_CHECK;
            miss_d  = '0;
          end
        end
        PH_CHECK: begin
          if (b == (sum_q & cfg_i.checksum_mask)) begin
            emit         = 1'b1;
            out_d.status = ST_FRAME_OK;
            for (int j = 0; j < SHOWN_BYTES; j++) begin
              if (j < PAYLOAD_BYTES) begin
                out_d.payload[j] = store_q[j];
              end
            end
            phase_d = PH_HUNT;
            miss_d  = '0;
          end else if (miss_hit) begin
            emit         = 1'b1;
            out_d.status = ST_BAD_SUM;
            phase_d      = PH_HUNT;
            miss_d       = '0;
          end else begin
            miss_d = miss_inc;
          end
        end
        default: begin
          // Hunting; the unused phase code falls back here too.
          phase_d = PH_HUNT;
          if (b == cfg_i.start_marker) begin
            phase_d = PH_DATA;
            idx_d   = '0;
            sum_d   = '0;
            miss_d  = '0;
          end else if (miss_hit) begin
            emit         = 1'b1;
            out_d.status = ST_NO_START;
            miss_d       = '0;
          end else begin
            miss_d = miss_inc;
          end
        end
      endcase
    end

    if (advance) begin
      out_valid_d = emit;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      idx_q       <= '0;
      miss_q      <= '0;
      sum_q       <= '0;
      store_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      miss_q      <= miss_d;
      sum_q       <= sum_d;
      store_q     <= store_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res.valid        = out_valid_q;
  assign res.frame_status = out_q.status;
  assign res.payload_0    = out_q.payload[0];
  assign res.payload_1    = out_q.payload[1];
  assign res.payload_2    = out_q.payload[2];
  assign res.payload_3    = out_q.payload[3];
  assign res.payload_4    = out_q.payload[4];
  assign res.payload_5    = out_q.payload[5];

endmodule
`default_nettype wire

// ===== design/sum_checked_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// Start-marker framed byte receiver with a masked additive checksum.
//
//   channel   dir   payload                               handshake
//   rx_i      in    rx_byte[7:0]                          valid / ready
//   res_o     out   frame_status[1:0], payload_0..5[7:0]  valid / ready
//   cfg       in    cfg_idx_i[1:0], cfg_data_i[7:0]       cfg_we_i, no wait
//
// Every byte passes through the input register, one step of the frame state
// machine and the result register. A byte may enter every cycle while res_o
// is not stalled.
// Reset loads the default registers (marker 0x80, mask 0x7f, miss limit 10)
// and starts hunting with an empty sum and cleared payload store.
// A stall on res_o holds the result register; the core then stops taking
// bytes, and the input register absorbs one more before rx_i.ready drops.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  frx_byte_if.sink                            rx_i,
  frx_result_if.source                        res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [frx_pkg::BYTE_W-1:0]    cfg_data_i
);
  import frx_pkg::*;

  cfg_t cfg;

  // Registered byte between the input stage and the core.
  frx_byte_if core_byte ();

  // Hold start marker, checksum mask and miss limit.
  frx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Capture each incoming item so the core sees a registered byte.
  frx_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx_i),
    .core   (core_byte)
  );

  // Run hunt / collect / check and register the result.
  frx_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in     (core_byte),
    .res    (res_o)
  );

endmodule
`default_nettype wire
